[hdl/bldc_hall_commutation_speed_loop_top_defines.svh]
// Assertion macros used by the checker file of the commutation block.
`ifndef BLDC_HALL_COMMUTATION_SPEED_LOOP_TOP_DEFINES_SVH
`define BLDC_HALL_COMMUTATION_SPEED_LOOP_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define BHC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define BHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/bhc_pkg.sv]
// Shared types, tables and constants of the hall commutation / speed loop block.
package bhc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROTOR_OFFSET = 2'd0,
        CFG_TARGET_SPEED = 2'd1,
        CFG_SPEED_GAIN   = 2'd2
    } cfg_idx_t;

    localparam logic [7:0]  SPEED_GAIN_RESET = 8'd25;
    localparam logic [5:0]  PHASE_XOR        = 6'h2A;
    localparam logic [5:0]  PINS_RESET       = 6'h38;
    localparam logic [12:0] DUTY_FULL        = 13'd4096;
    localparam logic [2:0]  ROTOR_FIVE       = 3'd5;
    localparam logic [2:0]  ROTOR_ZERO       = 3'd0;

    // Lead of +2 / -2 folded together with a bias of 12 so the sum stays positive.
    localparam logic [4:0]  LEAD_FWD_BIAS    = 5'd14;
    localparam logic [4:0]  LEAD_REV_BIAS    = 5'd10;

    // x / 3 == (x * DIV3_RECIP) >> DIV3_SHIFT, exact for x < 2**19.
    localparam logic [17:0] DIV3_RECIP       = 18'd174763;
    localparam int          DIV3_SHIFT       = 19;

    // Hall code to rotor state; codes 0 and 7 are invalid and map to 7.
    localparam logic [2:0] ROTOR_TAB [8] = '{
        3'd7, 3'd5, 3'd3, 3'd4, 3'd1, 3'd0, 3'd2, 3'd7
    };

    // Drive state to gate pattern before the active-low fix-up.
    localparam logic [5:0] DRIVE_TAB [8] = '{
        6'h12, 6'h18, 6'h09, 6'h21, 6'h24, 6'h06, 6'h00, 6'h00
    };

    // Handed from the commutation stage to the torque stage.
    typedef struct packed {
        logic        op;
        logic [5:0]  pins;
        logic        reverse;
        logic [15:0] position;
        logic [16:0] velocity;
        logic [21:0] diff;
    } mid_t;

    // One finished result.
    typedef struct packed {
        logic [5:0]  pins;
        logic [12:0] duty;
        logic        reverse;
        logic [15:0] position;
        logic [16:0] velocity;
        logic [28:0] torque;
    } res_t;

endpackage

[hdl/bldc_hall_commutation_speed_loop_top.sv]
// Top level of the six-step hall commutation block with proportional speed loop.
//
// Each input beat is either a hall event (s_op = 0, sensor bits on s_hall_bits)
// or a control tick (s_op = 1), and every beat yields exactly one result beat.
// A hall event decodes the rotor state; if it moved, the signed position count
// steps by one (5 -> 0 counts up, 0 -> 5 counts down) and a new gate pattern
// is driven for drive state (rotor - rotor_offset + lead) mod 6, high side
// active low. A tick computes velocity = delta position * 10 / 6 (truncated),
// torque = (target_speed - 16 * velocity) * speed_gain in Q4, picks the lead
// from the torque sign (m_reverse) and sets the Q12 duty to |torque| * 256,
// clamped at 4096. Throughput is one beat per clock; a result is presented on
// m_valid once its beat has passed the input register, the commutation stage
// (the divide-by-three multiply for velocity) and then the torque stage (the
// gain multiply), whose registers are the result register.
// Each stage advances whenever the one after it is empty or moving, so input
// keeps flowing while a result waits on m_ready until all three registers are
// full. Configuration is a
// plain write port (index 0 rotor_offset, 1 target_speed, 2 speed_gain,
// index 3 ignored) and must only be written while no beat is in flight.
module bldc_hall_commutation_speed_loop_top (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [bhc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bhc_pkg::CFG_DATA_W-1:0]      cfg_wdata,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic [2:0]                          s_hall_bits,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [5:0]                          m_phase_pins,
    output logic [12:0]                         m_duty,
    output logic                                m_reverse,
    output logic signed [15:0]                  m_position,
    output logic signed [16:0]                  m_velocity,
    output logic signed [28:0]                  m_torque_cmd
);
    import bhc_pkg::*;

    // Configuration registers
    logic [2:0]  rotor_offset_reg;
    logic [14:0] target_speed_reg;
    logic [7:0]  speed_gain_reg;

    // Pipeline occupancy
    logic in_valid_reg;
    logic mid_valid_reg;
    logic out_valid_reg;
    logic in_en;
    logic mid_en;
    logic out_en;

    // Input register payload
    logic       in_op_reg;
    logic [2:0] in_hall_reg;

    mid_t mid;
    res_t res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotor_offset_reg <= 3'd0;
            target_speed_reg <= 15'd0;
            speed_gain_reg   <= SPEED_GAIN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ROTOR_OFFSET: rotor_offset_reg <= cfg_wdata[2:0];
                CFG_TARGET_SPEED: target_speed_reg <= cfg_wdata[14:0];
                CFG_SPEED_GAIN:   speed_gain_reg   <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or its beat moves on this cycle
    assign out_en  = !out_valid_reg || m_ready;
    assign mid_en  = !mid_valid_reg || out_en;
    assign in_en   = !in_valid_reg  || mid_en;
    assign s_ready = in_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_en) begin
                in_valid_reg <= s_valid;
            end
            if (mid_en) begin
                mid_valid_reg <= in_valid_reg;
            end
            if (out_en) begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && in_en) begin
            in_op_reg   <= s_op;
            in_hall_reg <= s_hall_bits;
        end
    end

    bhc_commutator u_commutator (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .upd_i          (mid_en && in_valid_reg),
        .op_i           (in_op_reg),
        .hall_i         (in_hall_reg),
        .rotor_offset_i (rotor_offset_reg),
        .target_speed_i (target_speed_reg),
        .speed_gain_i   (speed_gain_reg),
        .mid_o          (mid)
    );

    bhc_torque u_torque (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load_i       (out_en && mid_valid_reg),
        .mid_i        (mid),
        .speed_gain_i (speed_gain_reg),
        .res_o        (res)
    );

    assign m_valid      = out_valid_reg;
    assign m_phase_pins = res.pins;
    assign m_duty       = res.duty;
    assign m_reverse    = res.reverse;
    assign m_position   = $signed(res.position);
    assign m_velocity   = $signed(res.velocity);
    assign m_torque_cmd = $signed(res.torque);

endmodule

[hdl/bhc_commutator.sv]
// Commutation stage: rotor decode, step count, drive pattern, velocity and speed error.
module bhc_commutator (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          upd_i,
    input  logic          op_i,
    input  logic [2:0]    hall_i,
    input  logic [2:0]    rotor_offset_i,
    input  logic [14:0]   target_speed_i,
    input  logic [7:0]    speed_gain_i,
    output bhc_pkg::mid_t mid_o
);
    import bhc_pkg::*;

    logic [2:0]  prev_rotor_reg;
    logic [15:0] step_reg;
    logic [15:0] prev_step_reg;
    logic        reverse_reg;
    logic [5:0]  pins_reg;
    logic [16:0] velocity_reg;
    logic        op_reg;
    logic [21:0] diff_reg;

    logic [2:0]  rot;
    logic        changed;
    logic        count_up;
    logic [4:0]  phase_sum;
    logic [2:0]  drive_state;
    logic [5:0]  pins_next;
    logic [15:0] step_next;

    logic [15:0] delta;
    logic [18:0] delta_x5;
    logic [17:0] mag_x5;
    logic [35:0] div_prod;
    logic [16:0] quot;
    logic [16:0] velocity_next;
    logic [21:0] diff_next;
    logic        reverse_next;

    // Hall path
    always_comb begin
        rot       = ROTOR_TAB[hall_i];
        changed   = (rot != prev_rotor_reg);
        count_up  = ((rot > prev_rotor_reg) &&
                     !(rot == ROTOR_FIVE && prev_rotor_reg == ROTOR_ZERO)) ||
                    (rot == ROTOR_ZERO && prev_rotor_reg == ROTOR_FIVE);
        step_next = count_up ? step_reg + 16'd1 : step_reg - 16'd1;

        phase_sum = {2'b00, rot} + (reverse_reg ? LEAD_REV_BIAS : LEAD_FWD_BIAS)
                    - {2'b00, rotor_offset_i};
        if (phase_sum >= 5'd18) begin
            drive_state = 3'(phase_sum - 5'd18);
        end else if (phase_sum >= 5'd12) begin
            drive_state = 3'(phase_sum - 5'd12);
        end else if (phase_sum >= 5'd6) begin
            drive_state = 3'(phase_sum - 5'd6);
        end else begin
            drive_state = phase_sum[2:0];
        end
        pins_next = DRIVE_TAB[drive_state] ^ PHASE_XOR;
    end

    // Tick path: velocity = delta * 5 / 3, truncated toward zero
    always_comb begin
        delta         = step_reg - prev_step_reg;
        delta_x5      = {{3{delta[15]}}, delta} + {delta[15], delta, 2'b00};
        mag_x5        = delta[15] ? 18'(-delta_x5) : delta_x5[17:0];
        div_prod      = mag_x5 * DIV3_RECIP;
        quot          = div_prod[35:DIV3_SHIFT];
        velocity_next = delta[15] ? -quot : quot;
        diff_next     = {{7{target_speed_i[14]}}, target_speed_i}
                        - {velocity_next[16], velocity_next, 4'b0000};
        reverse_next  = diff_next[21] && (speed_gain_i != 8'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_rotor_reg <= 3'd0;
            step_reg       <= 16'd0;
            prev_step_reg  <= 16'd0;
            reverse_reg    <= 1'b0;
            pins_reg       <= PINS_RESET;
            velocity_reg   <= 17'd0;
        end else if (upd_i) begin
            if (op_i) begin
                velocity_reg  <= velocity_next;
                reverse_reg   <= reverse_next;
                prev_step_reg <= step_reg;
            end else if (changed) begin
                step_reg       <= step_next;
                pins_reg       <= pins_next;
                prev_rotor_reg <= rot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_i) begin
            op_reg   <= op_i;
            diff_reg <= diff_next;
        end
    end

    always_comb begin
        mid_o.op       = op_reg;
        mid_o.pins     = pins_reg;
        mid_o.reverse  = reverse_reg;
        mid_o.position = step_reg;
        mid_o.velocity = velocity_reg;
        mid_o.diff     = diff_reg;
    end

endmodule

[hdl/bhc_torque.sv]
// Torque stage: gain multiply, duty clamp and the result register.
module bhc_torque (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load_i,
    input  bhc_pkg::mid_t mid_i,
    input  logic [7:0]    speed_gain_i,
    output bhc_pkg::res_t res_o
);
    import bhc_pkg::*;

    logic signed [29:0] prod;
    logic [29:0]        mag;
    logic [12:0]        duty_next;

    logic [5:0]  pins_reg;
    logic        reverse_reg;
    logic [15:0] position_reg;
    logic [16:0] velocity_reg;
    logic [12:0] duty_reg;
    logic [28:0] torque_reg;

    always_comb begin
        prod      = $signed(mid_i.diff) * $signed({1'b0, speed_gain_i});
        mag       = prod[29] ? 30'(-prod) : 30'(prod);
        duty_next = (|mag[29:4]) ? DUTY_FULL : {1'b0, mag[3:0], 8'h00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg   <= DUTY_FULL;
            torque_reg <= 29'd0;
        end else if (load_i && mid_i.op) begin
            duty_reg   <= duty_next;
            torque_reg <= prod[28:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            pins_reg     <= mid_i.pins;
            reverse_reg  <= mid_i.reverse;
            position_reg <= mid_i.position;
            velocity_reg <= mid_i.velocity;
        end
    end

    always_comb begin
        res_o.pins     = pins_reg;
        res_o.duty     = duty_reg;
        res_o.reverse  = reverse_reg;
        res_o.position = position_reg;
        res_o.velocity = velocity_reg;
        res_o.torque   = torque_reg;
    end

endmodule

[hdl/bhc_checker.sv]
// Port-level checker for the commutation block, bound to the top level.
`include "bldc_hall_commutation_speed_loop_top_defines.svh"

module bhc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [5:0]                     m_phase_pins,
    input logic [12:0]                    m_duty,
    input logic                           m_reverse,
    input logic signed [15:0]             m_position,
    input logic signed [28:0]             m_torque_cmd
);
    import bhc_pkg::*;

    logic [15:0] last_pos_reg;
    logic [15:0] pos_step;
    logic        step_ok;
    logic        torque_big;
    logic [64:0] out_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pos_reg <= 16'd0;
        end else if (m_valid && m_ready) begin
            last_pos_reg <= m_position;
        end
    end

    assign pos_step   = m_position - last_pos_reg;
    assign step_ok    = (pos_step == 16'd0) || (pos_step == 16'd1) || (pos_step == 16'hFFFF);
    assign torque_big = (m_torque_cmd >= 29'sd16) || (m_torque_cmd <= -29'sd16);
    assign out_word   = {m_phase_pins, m_duty, m_reverse, m_position, m_torque_cmd};

    `BHC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(out_word), "result changed while stalled")
    `BHC_ASSERT_NOW(a_pos_step, m_valid && m_ready, step_ok, "position moved by more than one step")
    `BHC_ASSERT_NOW(a_rev_sign, m_valid, m_reverse == m_torque_cmd[28], "reverse disagrees with torque sign")
    `BHC_ASSERT_NOW(a_duty_clamp, m_valid && torque_big, m_duty == DUTY_FULL, "large torque, duty not full")

endmodule

bind bldc_hall_commutation_speed_loop_top bhc_checker u_bhc_checker (.*);
